@@ design/gadsr_pkg.sv @@
package gadsr_pkg;

  // Fixed-point formats: envelope Q1.23, release factor Q0.23, gains Q1.16
  localparam int unsigned ENV_W   = 24;
  localparam int unsigned REL_W   = 23;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned AMP_W   = 17;

  localparam logic [ENV_W-1:0]  ENV_ONE        = 24'd8388608;
  // 0.001 in Q1.23
  localparam logic [ENV_W-1:0]  IDLE_THRESHOLD = 24'd8389;
  localparam logic [GAIN_W-1:0] GAIN_MAX       = 17'd65536;

  // amplitude * envelope, then times level; gain is the product >> 39
  localparam int unsigned P1_W    = AMP_W + ENV_W;
  localparam int unsigned ACC_W   = P1_W + LEVEL_W;
  localparam int unsigned GSHIFT  = 39;
  localparam int unsigned GRAW_W  = ACC_W - GSHIFT;

  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_ATTACK_STEP     = 3'd0,
    REG_DECAY_STEP      = 3'd1,
    REG_SUSTAIN_LEVEL   = 3'd2,
    REG_RELEASE_FACTOR  = 3'd3,
    REG_NOISE_AMPLITUDE = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    CS_WAIT,
    CS_ADV,
    CS_MUL1,
    CS_MUL2,
    CS_MUL3,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [ENV_W-1:0]  attack_step;
    logic [ENV_W-1:0]  decay_step;
    logic [ENV_W-1:0]  sustain_level;
    logic [REL_W-1:0]  release_factor;
    logic [AMP_W-1:0]  noise_amplitude;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic advance;
    logic mul1;
    logic mul2;
    logic mul3;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_status_t;

endpackage

@@ design/gadsr_regs.sv @@
module gadsr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gadsr_pkg::ADDR_W-1:0]  paddr,
  input  logic [gadsr_pkg::DATA_W-1:0]  pwdata,
  output logic [gadsr_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output gadsr_pkg::cfg_t               cfg
);

  gadsr_pkg::reg_idx_t idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = gadsr_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_step     <= 24'd19022;
      cfg.decay_step      <= 24'd951;
      cfg.sustain_level   <= 24'd4194304;
      cfg.release_factor  <= 23'd8387657;
      cfg.noise_amplitude <= 17'd0;
    end else if (wr) begin
      unique case (idx)
        gadsr_pkg::REG_ATTACK_STEP:     cfg.attack_step     <= pwdata[23:0];
        gadsr_pkg::REG_DECAY_STEP:      cfg.decay_step      <= pwdata[23:0];
        gadsr_pkg::REG_SUSTAIN_LEVEL:   cfg.sustain_level   <= pwdata[23:0];
        gadsr_pkg::REG_RELEASE_FACTOR:  cfg.release_factor  <= pwdata[22:0];
        gadsr_pkg::REG_NOISE_AMPLITUDE: cfg.noise_amplitude <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gadsr_pkg::REG_ATTACK_STEP:     prdata = {8'd0, cfg.attack_step};
      gadsr_pkg::REG_DECAY_STEP:      prdata = {8'd0, cfg.decay_step};
      gadsr_pkg::REG_SUSTAIN_LEVEL:   prdata = {8'd0, cfg.sustain_level};
      gadsr_pkg::REG_RELEASE_FACTOR:  prdata = {9'd0, cfg.release_factor};
      gadsr_pkg::REG_NOISE_AMPLITUDE: prdata = {15'd0, cfg.noise_amplitude};
      default:                        prdata = '0;
    endcase
  end

endmodule

@@ design/gadsr_ctrl.sv @@
module gadsr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  gadsr_pkg::dp_status_t  status,
  output gadsr_pkg::dp_cmd_t     cmd
);

  gadsr_pkg::ctrl_state_t state, state_next;
  logic                   out_valid, out_valid_next;
  logic                   out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gadsr_pkg::CS_WAIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gadsr_pkg::CS_WAIT: if (s_tvalid) state_next = gadsr_pkg::CS_ADV;
      gadsr_pkg::CS_ADV:  state_next = status.skip ? gadsr_pkg::CS_DONE : gadsr_pkg::CS_MUL1;
      gadsr_pkg::CS_MUL1: state_next = gadsr_pkg::CS_MUL2;
      gadsr_pkg::CS_MUL2: state_next = gadsr_pkg::CS_MUL3;
      gadsr_pkg::CS_MUL3: state_next = gadsr_pkg::CS_DONE;
      gadsr_pkg::CS_DONE: if (out_free) state_next = gadsr_pkg::CS_WAIT;
      default:            state_next = gadsr_pkg::CS_WAIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      gadsr_pkg::CS_WAIT: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      gadsr_pkg::CS_ADV:  cmd.advance  = 1'b1;
      gadsr_pkg::CS_MUL1: cmd.mul1     = 1'b1;
      gadsr_pkg::CS_MUL2: cmd.mul2     = 1'b1;
      gadsr_pkg::CS_MUL3: cmd.mul3     = 1'b1;
      gadsr_pkg::CS_DONE: cmd.load_out = out_free;
      default: ;
    endcase
  end

  // Output word register: fill on load, drop when taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ design/gadsr_dp.sv @@
module gadsr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  gadsr_pkg::cfg_t              cfg,
  input  logic [gadsr_pkg::IN_W-1:0]   s_tdata,
  input  gadsr_pkg::dp_cmd_t           cmd,
  output gadsr_pkg::dp_status_t        status,
  output logic [gadsr_pkg::OUT_W-1:0]  m_tdata
);

  localparam int unsigned EW = gadsr_pkg::ENV_W;

  // envelope state
  gadsr_pkg::stage_t  env_stage, env_stage_next;
  logic [EW-1:0]      env_value, env_value_next;
  logic               gate_was_open;

  // latched tick and multiply sequence
  logic [gadsr_pkg::LEVEL_W-1:0] level;
  logic                          present;
  logic [gadsr_pkg::P1_W-1:0]    p1;
  logic [gadsr_pkg::ACC_W-1:0]   acc;
  logic [gadsr_pkg::OUT_W-1:0]   out_data;

  logic                 gate;
  gadsr_pkg::stage_t    stage_e;
  logic [EW-1:0]        value_e;
  logic [EW-1:0]        sus;
  logic [EW:0]          att_sum;
  logic signed [EW:0]   dec_diff;
  logic [EW+gadsr_pkg::REL_W-1:0] rel_prod;
  logic [EW-1:0]        rel_v;
  logic [gadsr_pkg::P1_W-1:0]   p1_prod;
  logic [gadsr_pkg::P1_W-1:0]   lo_prod;
  logic [gadsr_pkg::P1_W-EW+gadsr_pkg::LEVEL_W-1:0] hi_prod;
  logic [gadsr_pkg::GRAW_W-1:0] gain_raw;
  logic [gadsr_pkg::GAIN_W-1:0] gain;

  assign status.skip = !present || (cfg.noise_amplitude == '0);
  assign gate        = (level != '0);
  assign sus         = (cfg.sustain_level > gadsr_pkg::ENV_ONE) ? gadsr_pkg::ENV_ONE
                                                                : cfg.sustain_level;

  // gate edges first
  always_comb begin
    stage_e = env_stage;
    value_e = env_value;
    if (gate && !gate_was_open) begin
      stage_e = gadsr_pkg::STG_ATTACK;
      value_e = '0;
    end else if (!gate && gate_was_open && env_stage != gadsr_pkg::STG_IDLE) begin
      stage_e = gadsr_pkg::STG_RELEASE;
    end
  end

  assign att_sum  = {1'b0, value_e} + {1'b0, cfg.attack_step};
  assign dec_diff = $signed({1'b0, value_e}) - $signed({1'b0, cfg.decay_step});
  assign rel_prod = value_e * cfg.release_factor;
  assign rel_v    = rel_prod[EW+gadsr_pkg::REL_W-1:gadsr_pkg::REL_W];

  // then advance the envelope one tick
  always_comb begin
    env_stage_next = stage_e;
    env_value_next = value_e;
    unique case (stage_e)
      gadsr_pkg::STG_ATTACK: begin
        if (att_sum >= {1'b0, gadsr_pkg::ENV_ONE}) begin
          env_value_next = gadsr_pkg::ENV_ONE;
          env_stage_next = gadsr_pkg::STG_DECAY;
        end else begin
          env_value_next = att_sum[EW-1:0];
        end
      end
      gadsr_pkg::STG_DECAY: begin
        if (dec_diff <= $signed({1'b0, sus})) begin
          env_value_next = sus;
          env_stage_next = gadsr_pkg::STG_SUSTAIN;
        end else begin
          env_value_next = dec_diff[EW-1:0];
        end
      end
      gadsr_pkg::STG_SUSTAIN: env_value_next = sus;
      gadsr_pkg::STG_RELEASE: begin
        if (rel_v < gadsr_pkg::IDLE_THRESHOLD) begin
          env_value_next = '0;
          env_stage_next = gadsr_pkg::STG_IDLE;
        end else begin
          env_value_next = rel_v;
        end
      end
      default: begin
        env_value_next = '0;
        env_stage_next = gadsr_pkg::STG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_stage     <= gadsr_pkg::STG_IDLE;
      env_value     <= '0;
      gate_was_open <= 1'b0;
    end else if (cmd.advance && !status.skip) begin
      env_stage     <= env_stage_next;
      env_value     <= env_value_next;
      gate_was_open <= gate;
    end
  end

  // gain: split the 41 x 17 product into two partial products
  assign p1_prod = cfg.noise_amplitude * env_value;
  assign lo_prod = p1[EW-1:0] * level;
  assign hi_prod = p1[gadsr_pkg::P1_W-1:EW] * level;

  assign gain_raw = acc[gadsr_pkg::ACC_W-1:gadsr_pkg::GSHIFT];
  assign gain     = (gain_raw > gadsr_pkg::GRAW_W'(gadsr_pkg::GAIN_MAX))
                    ? gadsr_pkg::GAIN_MAX : gain_raw[gadsr_pkg::GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      level   <= s_tdata[gadsr_pkg::LEVEL_W-1:0];
      present <= s_tdata[gadsr_pkg::LEVEL_W];
    end
    if (cmd.mul1) p1 <= p1_prod;
    if (cmd.mul2) acc <= gadsr_pkg::ACC_W'(lo_prod);
    if (cmd.mul3) acc <= acc + {hi_prod, {EW{1'b0}}};
    if (cmd.load_out) begin
      out_data <= {3'd0,
                   (env_value != '0),
                   (status.skip || env_value == '0) ? {gadsr_pkg::GAIN_W{1'b0}} : gain,
                   env_stage,
                   env_value};
    end
  end

  assign m_tdata = out_data;

endmodule

@@ design/gated_adsr_envelope_top.sv @@
// Gated ADSR envelope generator. Each input word is one audio tick; each tick
// yields exactly one output word with the envelope after the tick (Q1.23), its
// stage (0 idle, 1 attack, 2 decay, 3 sustain, 4 release), the noise gain
// amplitude * envelope * level in Q1.16 and a sounding flag. A tick with
// partials_present clear, or with noise_amplitude at zero, leaves the state
// alone and reports a gain of zero. Each tick is accepted, then the gate edges
// are detected and the envelope advanced, then the multiplier chain forms the
// gain (amplitude times envelope, then two partial products against the level),
// and last the output register is loaded once it is free; a skipped tick skips
// the multiplier chain. The next tick is accepted only after that load. The
// output register holds a finished word while the next tick is accepted.
// Program the step registers over the APB port only while no tick is in flight.
module gated_adsr_envelope_top (
  input  logic                          clk,
  input  logic                          rst,
  // slave side, tdata: envelope_level[16:0], partials_present[17], zero pad
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gadsr_pkg::IN_W-1:0]    s_tdata,
  // master side, tdata: envelope_value[23:0], stage[26:24],
  // noise_gain[43:27], sounding[44], zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gadsr_pkg::OUT_W-1:0]   m_tdata,
  // configuration, register i at byte address 4*i
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gadsr_pkg::ADDR_W-1:0]  paddr,
  input  logic [gadsr_pkg::DATA_W-1:0]  pwdata,
  output logic [gadsr_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  gadsr_pkg::cfg_t        cfg;
  gadsr_pkg::dp_cmd_t     cmd;
  gadsr_pkg::dp_status_t  status;

  // Register file for steps, sustain, release factor and amplitude
  gadsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence one tick: accept, advance, multiply, hand the word over
  gadsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Envelope state, gain multiplier chain and the output word register
  gadsr_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata)
  );

endmodule

@@ design/gadsr_checker.sv @@
module gadsr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [gadsr_pkg::OUT_W-1:0]  m_tdata
);

  // sounding flag follows the envelope value
  a_sounding: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44] == (m_tdata[23:0] != 24'd0)))
    else $error("sounding flag disagrees with envelope value");

  // envelope within one, stage code in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:0] <= gadsr_pkg::ENV_ONE) &&
                 (m_tdata[26:24] <= gadsr_pkg::STG_RELEASE))
    else $error("envelope or stage out of range");

  // silent envelope gives no gain; gain never above one
  a_gain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[43:27] <= gadsr_pkg::GAIN_MAX) &&
                 (m_tdata[44] || m_tdata[43:27] == 17'd0))
    else $error("gain out of range or nonzero while silent");

  // idle stage always reports a zero envelope
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[26:24] == gadsr_pkg::STG_IDLE) |-> (m_tdata[23:0] == 24'd0))
    else $error("idle stage with nonzero envelope");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word dropped or changed while stalled");

endmodule

bind gated_adsr_envelope_top gadsr_checker u_checker (.*);
